// ===== hdl/tclbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tclbs_pkg
// shared codes and types for the two-color led blink sequencer
// ----------------------------------------------------------------------------
package tclbs_pkg;

    // request opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // per-request status flags from the step logic
    typedef struct packed {
        logic swapped;
        logic finished;
    } status_t;

endpackage

// ===== hdl/tclbs_core.sv =====
// ----------------------------------------------------------------------------
// tclbs_core
// sequence state and the single-pass step logic for one request
// ----------------------------------------------------------------------------
module tclbs_core #(
    parameter int CHANNEL_BITS  = 8,
    parameter int DURATION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  logic                                 opcode,
    input  logic [2:0][CHANNEL_BITS-1:0]         first_color,
    input  logic [2:0][CHANNEL_BITS-1:0]         second_color,
    input  logic [DURATION_BITS-1:0]             first_duration,
    input  logic [DURATION_BITS-1:0]             second_duration,
    input  logic [DURATION_BITS-1:0]             repeat_count,
    output logic [2:0][CHANNEL_BITS-1:0]         drive_color,
    output logic [DURATION_BITS:0]               phase_count,
    output tclbs_pkg::status_t                   status
);
    import tclbs_pkg::*;

    logic [2:0][CHANNEL_BITS-1:0] shown_color_reg,    shown_color_next;
    logic [2:0][CHANNEL_BITS-1:0] waiting_color_reg,  waiting_color_next;
    logic [DURATION_BITS-1:0]     shown_dur_reg,      shown_dur_next;
    logic [DURATION_BITS-1:0]     waiting_dur_reg,    waiting_dur_next;
    logic [DURATION_BITS-1:0]     repetitions_reg,    repetitions_next;
    logic [DURATION_BITS:0]       phases_reg,         phases_next;
    logic [DURATION_BITS:0]       elapsed_reg,        elapsed_next;

    // values after load or tick, before the swap decision
    logic [2:0][CHANNEL_BITS-1:0] sc_pre, wc_pre;
    logic [DURATION_BITS-1:0]     sd_pre, wd_pre, rep_pre;
    logic [DURATION_BITS:0]       ph_pre, el_pre;
    logic                         running, swap;

    always_comb
    begin
        if (opcode == OP_LOAD)
        begin
            sc_pre  = first_color;
            wc_pre  = second_color;
            sd_pre  = first_duration;
            wd_pre  = second_duration;
            rep_pre = repeat_count;
            ph_pre  = '0;
            el_pre  = '0;
        end
        else
        begin
            sc_pre  = shown_color_reg;
            wc_pre  = waiting_color_reg;
            sd_pre  = shown_dur_reg;
            wd_pre  = waiting_dur_reg;
            rep_pre = repetitions_reg;
            ph_pre  = phases_reg;
            // saturate at 2^DURATION_BITS (top bit set)
            el_pre  = elapsed_reg[DURATION_BITS] ? elapsed_reg
                                                 : elapsed_reg + 1'b1;
        end

        running = (rep_pre == '0) || (ph_pre < {rep_pre, 1'b0});
        swap    = running && (el_pre > {1'b0, sd_pre}) && (wd_pre != '0);

        shown_color_next   = swap ? wc_pre : sc_pre;
        waiting_color_next = swap ? sc_pre : wc_pre;
        shown_dur_next     = swap ? wd_pre : sd_pre;
        waiting_dur_next   = swap ? sd_pre : wd_pre;
        repetitions_next   = rep_pre;
        elapsed_next       = swap ? '0 : el_pre;
        if (swap && !(&ph_pre))
            phases_next = ph_pre + 1'b1;
        else
            phases_next = ph_pre;

        drive_color     = running ? shown_color_next : '0;
        phase_count     = phases_next;
        status.swapped  = swap;
        status.finished = !running;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_color_reg   <= '0;
            waiting_color_reg <= '0;
            shown_dur_reg     <= '0;
            waiting_dur_reg   <= '0;
            repetitions_reg   <= '0;
            phases_reg        <= '0;
            elapsed_reg       <= '0;
        end
        else if (fire)
        begin
            shown_color_reg   <= shown_color_next;
            waiting_color_reg <= waiting_color_next;
            shown_dur_reg     <= shown_dur_next;
            waiting_dur_reg   <= waiting_dur_next;
            repetitions_reg   <= repetitions_next;
            phases_reg        <= phases_next;
            elapsed_reg       <= elapsed_next;
        end
    end

    a_finished_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.finished |-> !status.swapped)
        else $error("swap reported on a finished sequence");

    a_swap_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.swapped |=> elapsed_reg == '0)
        else $error("elapsed time not cleared after swap");

    a_load_clears_phases: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (opcode == OP_LOAD) |=> phases_reg == '0)
        else $error("phase count not cleared by load");

    a_idle_holds_phases: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phases_reg))
        else $error("phase count changed without a request");

endmodule

// ===== hdl/two_color_led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// two_color_led_blink_sequencer
// two-color rgb led blink sequencer with valid/ready request channels
// ----------------------------------------------------------------------------
// path: input register, then result register; a request waits in the input
//   register while out_ready holds a result (single short step-logic pass)
// throughput: one request per cycle while out_ready does not stall the results
// reset: asynchronous active-low, clears both pipeline valids and all
//   sequence state (black colors, zero durations, endless mode)
module two_color_led_blink_sequencer #(
    parameter int CHANNEL_BITS  = 8,
    parameter int DURATION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [CHANNEL_BITS-1:0]   first_red,
    input  logic [CHANNEL_BITS-1:0]   first_green,
    input  logic [CHANNEL_BITS-1:0]   first_blue,
    input  logic [CHANNEL_BITS-1:0]   second_red,
    input  logic [CHANNEL_BITS-1:0]   second_green,
    input  logic [CHANNEL_BITS-1:0]   second_blue,
    input  logic [DURATION_BITS-1:0]  first_duration,
    input  logic [DURATION_BITS-1:0]  second_duration,
    input  logic [DURATION_BITS-1:0]  repeat_count,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHANNEL_BITS-1:0]   drive_red,
    output logic [CHANNEL_BITS-1:0]   drive_green,
    output logic [CHANNEL_BITS-1:0]   drive_blue,
    output logic [DURATION_BITS:0]    phase_count,
    output logic                      swapped,
    output logic                      finished
);
    import tclbs_pkg::*;

    // input register stage
    logic                         stage_valid_reg;
    logic                         opcode_reg;
    logic [2:0][CHANNEL_BITS-1:0] first_color_reg;
    logic [2:0][CHANNEL_BITS-1:0] second_color_reg;
    logic [DURATION_BITS-1:0]     first_dur_reg;
    logic [DURATION_BITS-1:0]     second_dur_reg;
    logic [DURATION_BITS-1:0]     repeat_reg;

    // result register stage
    logic                         out_valid_reg;
    logic [2:0][CHANNEL_BITS-1:0] drive_reg;
    logic [DURATION_BITS:0]       phase_reg;
    status_t                      status_reg;

    // step logic outputs
    logic [2:0][CHANNEL_BITS-1:0] drive_color;
    logic [DURATION_BITS:0]       core_phase;
    status_t                      core_status;

    logic advance;   // staged request moves into the result register
    logic in_fire;

    // the result register frees up when it is empty or being taken
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    // payload captured only on an accepted request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg       <= opcode;
            first_color_reg  <= {first_blue, first_green, first_red};
            second_color_reg <= {second_blue, second_green, second_red};
            first_dur_reg    <= first_duration;
            second_dur_reg   <= second_duration;
            repeat_reg       <= repeat_count;
        end
    end

    // sequence state and single-pass step
    tclbs_core #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .opcode          (opcode_reg),
        .first_color     (first_color_reg),
        .second_color    (second_color_reg),
        .first_duration  (first_dur_reg),
        .second_duration (second_dur_reg),
        .repeat_count    (repeat_reg),
        .drive_color     (drive_color),
        .phase_count     (core_phase),
        .status          (core_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg  <= drive_color;
            phase_reg  <= core_phase;
            status_reg <= core_status;
        end
    end

    // result ports (color channel 0 is red, 2 is blue)
    assign out_valid   = out_valid_reg;
    assign drive_red   = drive_reg[0];
    assign drive_green = drive_reg[1];
    assign drive_blue  = drive_reg[2];
    assign phase_count = phase_reg;
    assign swapped     = status_reg.swapped;
    assign finished    = status_reg.finished;

endmodule
